// ----- hdl/mfs_pkg.sv -----
// Shared constants, codes and helpers for the multilevel feedback scheduler.
// No dependencies; used by the top level, the checker and the testbench.
package mfs_pkg;

  // field widths
  localparam int ID_W      = 4;
  localparam int LVL_W     = 4;
  localparam int TIME_W    = 16;
  localparam int WORK_W    = 16;
  localparam int CNT_W     = 5;
  localparam int PTR_W     = 4;
  localparam int LVCFG_W   = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 5;

  // sizing
  localparam int FIFO_DEPTH = 16;
  localparam int ID_SLOTS   = 16;
  localparam int MAX_PROCS  = 16;
  localparam int LEVELS_DEF = 16;

  // reset value of the level count register
  localparam logic [LVCFG_W-1:0] LEVELS_IN_USE_RST = 5'd16;

  // request kinds
  localparam logic REQ_ARRIVAL = 1'b0;
  localparam logic REQ_TICK    = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_MODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVELS_IN_USE = 1'b1;

  typedef logic [ID_W-1:0]   id_t;
  typedef logic [LVL_W-1:0]  lvl_t;
  typedef logic [WORK_W-1:0] work_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [PTR_W-1:0]  ptr_t;

  // quantum length of a level: one tick, or 2^level in doubling mode
  function automatic logic [TIME_W-1:0] quantum_len(input logic mode, input lvl_t lvl);
    logic [TIME_W-1:0] one;
    one = TIME_W'(1);
    return mode ? (one << lvl) : one;
  endfunction

endpackage

// ----- hdl/mfs_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// No dependencies; holds the level queue entries of the scheduler.
module mfs_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hdl/multilevel_feedback_scheduler_top.sv -----
// Multilevel feedback queue scheduler top level. Uses mfs_pkg and mfs_ram.
// A tick word that is accepted loads its result word into the output
// register; an arrival word makes no result.
// Throughput: one word per cycle while the output register is not stalled,
// set by the queue update and level priority encode; the next-head RAM read is hidden.
// Reset: asynchronous, active low; clears queues, work counts and control.
module multilevel_feedback_scheduler_top #(
  parameter int LEVELS = mfs_pkg::LEVELS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mfs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mfs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            req_type_i,
  input  logic [mfs_pkg::ID_W-1:0]        proc_id_i,
  input  logic [mfs_pkg::WORK_W-1:0]      service_time_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            ran_valid_o,
  output logic [mfs_pkg::ID_W-1:0]        ran_id_o,
  output logic [mfs_pkg::LVL_W-1:0]       ran_level_o,
  output logic                            done_res_o,
  output logic [mfs_pkg::TIME_W-1:0]      tick_time_o
);

  localparam int RAM_DEPTH = LEVELS * mfs_pkg::FIFO_DEPTH;
  localparam int ADDR_W    = $clog2(RAM_DEPTH);

  // configuration
  logic                         quantum_mode_q;
  logic [mfs_pkg::LVCFG_W-1:0]  levels_in_use_q;

  // per-level queue control and cached front entry
  mfs_pkg::ptr_t head_q  [LEVELS];
  mfs_pkg::ptr_t tail_q  [LEVELS];
  mfs_pkg::cnt_t count_q [LEVELS];
  mfs_pkg::id_t  front_q [LEVELS];
  mfs_pkg::ptr_t head_d  [LEVELS];
  mfs_pkg::ptr_t tail_d  [LEVELS];
  mfs_pkg::cnt_t count_d [LEVELS];
  mfs_pkg::id_t  front_d [LEVELS];
  mfs_pkg::id_t  front_eff [LEVELS];

  // per-id work left
  mfs_pkg::work_t work_q [mfs_pkg::ID_SLOTS];
  mfs_pkg::work_t work_d [mfs_pkg::ID_SLOTS];
  logic [mfs_pkg::ID_SLOTS-1:0] id_busy;

  // current run
  mfs_pkg::id_t               cur_id_q, cur_id_d;
  mfs_pkg::lvl_t              cur_lvl_q, cur_lvl_d;
  logic [mfs_pkg::TIME_W-1:0] slice_q, slice_d;
  logic                       cur_active_q, cur_active_d;
  logic                       settle_q, settle_d;
  logic [mfs_pkg::TIME_W-1:0] slot_q, slot_d;

  // outstanding head refill from the RAM
  logic          refill_q, refill_d;
  mfs_pkg::lvl_t refill_lvl_q;

  // output register
  logic                       out_valid_q, out_valid_d;
  logic                       res_valid_q;
  mfs_pkg::id_t               res_id_q;
  mfs_pkg::lvl_t              res_lvl_q;
  logic                       res_done_q;
  logic [mfs_pkg::TIME_W-1:0] res_time_q;

  // item decode
  logic in_fire, tick_fire, arr_fire, arr_ok;

  // push side
  logic                        any_work;
  logic [mfs_pkg::LVCFG_W-1:0] lv_clamp, cap5, nxt5;
  mfs_pkg::lvl_t               settle_lvl, push_lvl;
  mfs_pkg::id_t                push_id;
  logic                        push_en;
  logic [LEVELS-1:0]           push_hit, pop_hit, nonempty_mid, refill_lane;
  mfs_pkg::cnt_t               cnt_mid [LEVELS];
  mfs_pkg::cnt_t               cnt_after [LEVELS];

  // pick and serve
  logic                       run_keep, need_pick, pick_found, srv_active, srv_done;
  mfs_pkg::lvl_t              pick_lvl, srv_lvl;
  mfs_pkg::id_t               pick_id, srv_id;
  logic [mfs_pkg::TIME_W-1:0] srv_slice, slice_next;
  mfs_pkg::work_t             srv_work, work_next;

  // RAM ports
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
  mfs_pkg::id_t         ram_rdata;
  mfs_pkg::ptr_t        rd_slot;

  // handshake: output register frees when its word leaves
  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign in_fire    = in_valid_i & in_ready_o;
  assign tick_fire  = in_fire & (req_type_i == mfs_pkg::REQ_TICK);
  assign arr_fire   = in_fire & (req_type_i == mfs_pkg::REQ_ARRIVAL);

  // id activity flags
  always_comb begin
    for (int i = 0; i < mfs_pkg::ID_SLOTS; i++) begin
      id_busy[i] = (work_q[i] != '0);
    end
  end

  assign arr_ok = (service_time_i != '0) && (int'(proc_id_i) < mfs_pkg::MAX_PROCS)
                  && !id_busy[proc_id_i];

  // settle level: demote one, capped at the last level in use, when work waits
  always_comb begin
    any_work = 1'b0;
    for (int l = 0; l < LEVELS; l++) begin
      any_work = any_work | (count_q[l] != '0);
    end
    if (levels_in_use_q == '0) begin
      lv_clamp = mfs_pkg::LVCFG_W'(1);
    end else if (int'(levels_in_use_q) > LEVELS) begin
      lv_clamp = mfs_pkg::LVCFG_W'(LEVELS);
    end else begin
      lv_clamp = levels_in_use_q;
    end
    cap5 = lv_clamp - mfs_pkg::LVCFG_W'(1);
    nxt5 = {1'b0, cur_lvl_q} + mfs_pkg::LVCFG_W'(1);
    if (nxt5 > cap5) begin
      nxt5 = cap5;
    end
    settle_lvl = any_work ? nxt5[mfs_pkg::LVL_W-1:0] : cur_lvl_q;
  end

  // push request: arrival to level 0 or settle of the expired run
  assign push_en  = (arr_fire & arr_ok) | (tick_fire & settle_q);
  assign push_lvl = tick_fire ? settle_lvl : '0;
  assign push_id  = tick_fire ? cur_id_q : proc_id_i;

  // per-level push hit and occupancy after the push
  always_comb begin
    for (int l = 0; l < LEVELS; l++) begin
      push_hit[l] = push_en && (int'(push_lvl) == l)
                    && (int'(count_q[l]) != mfs_pkg::FIFO_DEPTH);
      cnt_mid[l]      = count_q[l] + mfs_pkg::CNT_W'(push_hit[l]);
      nonempty_mid[l] = (cnt_mid[l] != '0);
    end
  end

  // pick the highest-priority nonempty level when nothing keeps running
  assign run_keep  = cur_active_q & ~settle_q;
  assign need_pick = tick_fire & ~run_keep;

  always_comb begin
    pick_found = 1'b0;
    pick_lvl   = '0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (nonempty_mid[l]) begin
        pick_found = 1'b1;
        pick_lvl   = mfs_pkg::LVL_W'(l);
      end
    end
  end

  // front entry seen this cycle: a fresh push, a landing refill, or the cache
  always_comb begin
    for (int l = 0; l < LEVELS; l++) begin
      if (count_q[l] == '0) begin
        front_eff[l] = push_id;
      end else if (refill_q && (int'(refill_lvl_q) == l)) begin
        front_eff[l] = ram_rdata;
      end else begin
        front_eff[l] = front_q[l];
      end
      pop_hit[l] = need_pick && pick_found && (int'(pick_lvl) == l);
    end
  end

  assign pick_id = front_eff[pick_lvl];

  // serve one unit of the current or newly picked process
  always_comb begin
    srv_active = run_keep | (need_pick & pick_found);
    srv_id     = run_keep ? cur_id_q : pick_id;
    srv_lvl    = run_keep ? cur_lvl_q : pick_lvl;
    srv_slice  = run_keep ? slice_q : mfs_pkg::quantum_len(quantum_mode_q, pick_lvl);
    srv_work   = work_q[srv_id];
    work_next  = (srv_work != '0) ? srv_work - mfs_pkg::WORK_W'(1) : '0;
    slice_next = (srv_slice != '0) ? srv_slice - mfs_pkg::TIME_W'(1) : '0;
    srv_done   = (work_next == '0);
  end

  // run state update
  always_comb begin
    cur_id_d     = cur_id_q;
    cur_lvl_d    = cur_lvl_q;
    slice_d      = slice_q;
    cur_active_d = cur_active_q;
    settle_d     = settle_q;
    slot_d       = slot_q;
    if (tick_fire) begin
      slot_d       = slot_q + mfs_pkg::TIME_W'(1);
      cur_active_d = 1'b0;
      settle_d     = 1'b0;
      if (srv_active) begin
        cur_id_d  = srv_id;
        cur_lvl_d = srv_lvl;
        slice_d   = slice_next;
        if (!srv_done) begin
          if (slice_next == '0) begin
            settle_d = 1'b1;
          end else begin
            cur_active_d = 1'b1;
          end
        end
      end
    end
  end

  // work counters per id
  always_comb begin
    for (int i = 0; i < mfs_pkg::ID_SLOTS; i++) begin
      work_d[i] = work_q[i];
      if (arr_fire && arr_ok && (int'(proc_id_i) == i)) begin
        work_d[i] = service_time_i;
      end
      if (tick_fire && srv_active && (int'(srv_id) == i)) begin
        work_d[i] = work_next;
      end
    end
  end

  // queue pointers, counts and front cache per level
  always_comb begin
    for (int l = 0; l < LEVELS; l++) begin
      head_d[l]      = head_q[l] + mfs_pkg::PTR_W'(pop_hit[l]);
      tail_d[l]      = tail_q[l] + mfs_pkg::PTR_W'(push_hit[l]);
      cnt_after[l]   = cnt_mid[l] - mfs_pkg::CNT_W'(pop_hit[l]);
      count_d[l]     = cnt_after[l];
      front_d[l]     = front_q[l];
      refill_lane[l] = 1'b0;
      if (pop_hit[l]) begin
        if (cnt_after[l] != '0) begin
          // next entry is the one pushed this cycle: take it directly
          if (push_hit[l] && (count_q[l] == mfs_pkg::CNT_W'(1))) begin
            front_d[l] = push_id;
          end else begin
            refill_lane[l] = 1'b1;
          end
        end
      end else begin
        if (refill_q && (int'(refill_lvl_q) == l)) begin
          front_d[l] = ram_rdata;
        end
        if (push_hit[l] && (count_q[l] == '0)) begin
          front_d[l] = push_id;
        end
      end
    end
  end

  assign refill_d = |refill_lane;

  // RAM addressing: write at the push tail, read the slot after the popped head
  assign rd_slot   = head_q[pick_lvl] + mfs_pkg::PTR_W'(1);
  assign ram_we    = |push_hit;
  assign ram_waddr = ADDR_W'({push_lvl, tail_q[push_lvl]});
  assign ram_raddr = ADDR_W'({pick_lvl, rd_slot});

  mfs_ram #(
    .WIDTH(mfs_pkg::ID_W),
    .DEPTH(RAM_DEPTH)
  ) u_queue_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(push_id),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // output register valid: load on a tick, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (tick_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_mode_q  <= 1'b0;
      levels_in_use_q <= mfs_pkg::LEVELS_IN_USE_RST;
      for (int l = 0; l < LEVELS; l++) begin
        head_q[l]  <= '0;
        tail_q[l]  <= '0;
        count_q[l] <= '0;
      end
      for (int i = 0; i < mfs_pkg::ID_SLOTS; i++) begin
        work_q[i] <= '0;
      end
      cur_id_q     <= '0;
      cur_lvl_q    <= '0;
      slice_q      <= '0;
      cur_active_q <= 1'b0;
      settle_q     <= 1'b0;
      slot_q       <= '0;
      refill_q     <= 1'b0;
      refill_lvl_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          mfs_pkg::CFG_QUANTUM_MODE:  quantum_mode_q  <= cfg_data_i[0];
          mfs_pkg::CFG_LEVELS_IN_USE: levels_in_use_q <= cfg_data_i;
          default: ;
        endcase
      end
      head_q       <= head_d;
      tail_q       <= tail_d;
      count_q      <= count_d;
      work_q       <= work_d;
      cur_id_q     <= cur_id_d;
      cur_lvl_q    <= cur_lvl_d;
      slice_q      <= slice_d;
      cur_active_q <= cur_active_d;
      settle_q     <= settle_d;
      slot_q       <= slot_d;
      refill_q     <= refill_d;
      refill_lvl_q <= pick_lvl;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers: front cache and result word
  always_ff @(posedge clk_i) begin
    front_q <= front_d;
    if (tick_fire) begin
      res_valid_q <= srv_active;
      res_id_q    <= srv_active ? srv_id : '0;
      res_lvl_q   <= srv_active ? srv_lvl : '0;
      res_done_q  <= srv_active & srv_done;
      res_time_q  <= slot_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign ran_valid_o = res_valid_q;
  assign ran_id_o    = res_id_q;
  assign ran_level_o = res_lvl_q;
  assign done_res_o  = res_done_q;
  assign tick_time_o = res_time_q;

endmodule

// ----- hdl/mfs_checker.sv -----
// Port-level checks for the multilevel feedback scheduler top level.
// Uses mfs_pkg widths; bound to multilevel_feedback_scheduler_top below.
module mfs_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic                            ran_valid_o,
  input logic [mfs_pkg::ID_W-1:0]        ran_id_o,
  input logic [mfs_pkg::LVL_W-1:0]       ran_level_o,
  input logic                            done_res_o,
  input logic [mfs_pkg::TIME_W-1:0]      tick_time_o
);

  logic                       seen_q;
  logic [mfs_pkg::TIME_W-1:0] last_time_q;
  logic                       out_fire;

  assign out_fire = out_valid_o & out_ready_i;

  // track the time slot of the last delivered word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= 1'b0;
      last_time_q <= '0;
    end else if (out_fire) begin
      seen_q      <= 1'b1;
      last_time_q <= tick_time_o;
    end
  end

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(ran_id_o)
      && $stable(tick_time_o) && $stable(ran_valid_o))
    else $error("result word changed while stalled");

  // an idle slot reports zeros and no completion
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ran_valid_o |-> ran_id_o == '0 && ran_level_o == '0 && !done_res_o)
    else $error("idle slot carries process fields");

  // time slots of delivered words advance by one
  a_time_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && seen_q |-> tick_time_o == last_time_q + mfs_pkg::TIME_W'(1))
    else $error("time slot skipped or repeated");

  // the first word after reset is slot zero
  a_time_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !seen_q |-> tick_time_o == '0)
    else $error("first time slot is not zero");

endmodule

bind multilevel_feedback_scheduler_top mfs_checker u_mfs_checker (.*);

// ----- dv/tb_multilevel_feedback_scheduler_top.sv -----
// Self-checking testbench for the multilevel feedback scheduler top level.
// Depends on mfs_pkg and multilevel_feedback_scheduler_top; a built-in slot
// predictor checks every tick report against the queue state it keeps.
`timescale 1ns / 1ps

module tb_multilevel_feedback_scheduler_top;

  localparam int unsigned STALL_LIMIT = 2000;

  typedef struct packed {
    logic                         ran_valid;
    mfs_pkg::id_t                 ran_id;
    mfs_pkg::lvl_t                ran_level;
    logic                         done_res;
    logic [mfs_pkg::TIME_W-1:0]   tick_time;
  } slot_report_t;

  // DUT connections
  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic [mfs_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [mfs_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                           in_valid_i = 1'b0;
  logic                           in_ready_o;
  logic                           req_type_i = mfs_pkg::REQ_ARRIVAL;
  logic [mfs_pkg::ID_W-1:0]       proc_id_i = '0;
  logic [mfs_pkg::WORK_W-1:0]     service_time_i = '0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  logic                           ran_valid_o;
  logic [mfs_pkg::ID_W-1:0]       ran_id_o;
  logic [mfs_pkg::LVL_W-1:0]      ran_level_o;
  logic                           done_res_o;
  logic [mfs_pkg::TIME_W-1:0]     tick_time_o;

  multilevel_feedback_scheduler_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .proc_id_i      (proc_id_i),
    .service_time_i (service_time_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .ran_valid_o    (ran_valid_o),
    .ran_id_o       (ran_id_o),
    .ran_level_o    (ran_level_o),
    .done_res_o     (done_res_o),
    .tick_time_o    (tick_time_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Scheduler shadow state
  logic                        doubling_mode;
  logic [mfs_pkg::LVCFG_W-1:0] levels_reg;
  mfs_pkg::id_t    q_mem [mfs_pkg::LEVELS_DEF][mfs_pkg::FIFO_DEPTH];
  mfs_pkg::ptr_t   q_head [mfs_pkg::LEVELS_DEF];
  mfs_pkg::ptr_t   q_tail [mfs_pkg::LEVELS_DEF];
  mfs_pkg::cnt_t   q_count [mfs_pkg::LEVELS_DEF];
  mfs_pkg::work_t  work_left [mfs_pkg::ID_SLOTS];
  mfs_pkg::id_t    run_id;
  mfs_pkg::lvl_t   run_level;
  logic [mfs_pkg::TIME_W-1:0] slice_left;
  bit                         run_active;
  bit                         settle_due;
  logic [mfs_pkg::TIME_W-1:0] slot_now;

  slot_report_t       slot_reports[$];
  slot_report_t       want;

  // Run bookkeeping
  int unsigned mismatch_count;
  int unsigned reports_checked;
  int unsigned ticks_sent;
  int unsigned arrivals_taken;
  int unsigned settings_applied;
  int unsigned idle_cycles;
  int unsigned stall_left;
  bit          idle_on;
  bit          stall_on;

  function automatic void clear_shadow();
    doubling_mode = 1'b0;
    levels_reg    = mfs_pkg::LEVELS_IN_USE_RST;
    for (int l = 0; l < mfs_pkg::LEVELS_DEF; l++) begin
      q_head[l]  = '0;
      q_tail[l]  = '0;
      q_count[l] = '0;
      for (int e = 0; e < mfs_pkg::FIFO_DEPTH; e++) q_mem[l][e] = '0;
    end
    for (int i = 0; i < mfs_pkg::ID_SLOTS; i++) work_left[i] = '0;
    run_id     = '0;
    run_level  = '0;
    slice_left = '0;
    run_active = 1'b0;
    settle_due = 1'b0;
    slot_now   = '0;
  endfunction

  function automatic void enqueue(int unsigned lvl, mfs_pkg::id_t pid);
    if (q_count[lvl] >= mfs_pkg::FIFO_DEPTH) return;
    q_mem[lvl][q_tail[lvl]] = pid;
    q_tail[lvl]++;
    q_count[lvl]++;
  endfunction

  function automatic bit queues_busy();
    for (int l = 0; l < mfs_pkg::LEVELS_DEF; l++)
      if (q_count[l] != 0) return 1'b1;
    return 1'b0;
  endfunction

  // Clamp the level register to 1..LEVELS and return the deepest level
  function automatic int unsigned deepest_level();
    int unsigned n;
    n = levels_reg;
    if (n == 0) n = 1;
    if (n > mfs_pkg::LEVELS_DEF) n = mfs_pkg::LEVELS_DEF;
    return n - 1;
  endfunction

  // Admit a new process at level 0; returns 0 when the word is dropped
  function automatic bit admit_process(mfs_pkg::id_t pid, mfs_pkg::work_t svc);
    if (svc == 0 || work_left[pid] != 0) return 1'b0;
    work_left[pid] = svc;
    enqueue(0, pid);
    return 1'b1;
  endfunction

  // Serve one time slot and return the report the block should emit
  function automatic slot_report_t serve_slot();
    slot_report_t r;
    int unsigned  lvl;
    int unsigned  cap;
    bit           found;
    r = '0;
    // settle the process whose quantum ran out last tick
    if (settle_due) begin
      lvl = run_level;
      if (queues_busy()) begin
        cap = deepest_level();
        lvl = lvl + 1;
        if (lvl > cap) lvl = cap;
      end
      enqueue(lvl, run_id);
      settle_due = 1'b0;
      run_active = 1'b0;
    end
    // pick the front of the highest nonempty level
    if (!run_active) begin
      found = 1'b0;
      for (int l = 0; l < mfs_pkg::LEVELS_DEF; l++) begin
        if (!found && q_count[l] != 0) begin
          found     = 1'b1;
          run_level = mfs_pkg::lvl_t'(l);
        end
      end
      if (found) begin
        run_id = q_mem[run_level][q_head[run_level]];
        q_head[run_level]++;
        q_count[run_level]--;
        slice_left = doubling_mode ? (mfs_pkg::TIME_W'(1) << run_level)
                                   : mfs_pkg::TIME_W'(1);
        run_active = 1'b1;
      end
    end
    r.tick_time = slot_now;
    slot_now++;
    if (run_active) begin
      if (work_left[run_id] != 0) work_left[run_id]--;
      if (slice_left != 0) slice_left--;
      r.ran_valid = 1'b1;
      r.ran_id    = run_id;
      r.ran_level = run_level;
      if (work_left[run_id] == 0) begin
        r.done_res = 1'b1;
        run_active = 1'b0;
      end else if (slice_left == 0) begin
        settle_due = 1'b1;
        run_active = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic int unsigned gap_len();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  // Prefer ids with no work left so most arrivals are admitted
  function automatic mfs_pkg::id_t pick_arrival_id();
    int unsigned  start;
    mfs_pkg::id_t c;
    start = $urandom_range(0, mfs_pkg::ID_SLOTS - 1);
    if ($urandom_range(0, 99) < 75) begin
      for (int k = 0; k < mfs_pkg::ID_SLOTS; k++) begin
        c = mfs_pkg::id_t'(start + k);
        if (work_left[c] == 0) return c;
      end
    end
    return mfs_pkg::id_t'($urandom_range(0, mfs_pkg::ID_SLOTS - 1));
  endfunction

  // Send one word, hold it until accepted, then advance the shadow state
  task automatic send_word(input logic req, input mfs_pkg::id_t pid,
                           input mfs_pkg::work_t svc, output bit taken);
    int unsigned gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 99) < 30) gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    req_type_i     <= req;
    proc_id_i      <= pid;
    service_time_i <= svc;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    if (req == mfs_pkg::REQ_TICK) begin
      slot_reports.insert(slot_reports.size(), serve_slot());
      ticks_sent++;
      taken = 1'b1;
    end else begin
      taken = admit_process(pid, svc);
      if (taken) arrivals_taken++;
    end
  endtask

  task automatic send_tick();
    bit taken;
    send_word(mfs_pkg::REQ_TICK, mfs_pkg::id_t'($urandom), mfs_pkg::work_t'($urandom),
              taken);
  endtask

  task automatic send_arrival(input mfs_pkg::id_t pid, input mfs_pkg::work_t svc);
    bit taken;
    send_word(mfs_pkg::REQ_ARRIVAL, pid, svc, taken);
  endtask

  // Drop valid and wait until every pending report has been checked
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (slot_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write both registers; junk in the upper mode bits must be ignored
  task automatic apply_settings(input logic mode,
                                input logic [mfs_pkg::LVCFG_W-1:0] levels);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= mfs_pkg::CFG_QUANTUM_MODE;
    cfg_data_i  <= {mfs_pkg::CFG_DATA_W'($urandom) & ~mfs_pkg::CFG_DATA_W'(1)}
                   | mfs_pkg::CFG_DATA_W'(mode);
    @(posedge clk_i);
    doubling_mode = mode;
    cfg_index_i <= mfs_pkg::CFG_LEVELS_IN_USE;
    cfg_data_i  <= levels;
    @(posedge clk_i);
    levels_reg = levels;
    cfg_we_i <= 1'b0;
    settings_applied++;
  endtask

  // Random arrivals and ticks; dropped arrivals do not count
  task automatic run_traffic(input int unsigned n_items, input int unsigned arrival_pct);
    int unsigned    sent;
    int unsigned    pick;
    mfs_pkg::id_t   pid;
    mfs_pkg::work_t svc;
    bit             taken;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 39) == 0) begin
        idle_on  = ($urandom_range(0, 2) != 0);
        stall_on = ($urandom_range(0, 2) != 0);
      end
      if ($urandom_range(0, 99) < arrival_pct) begin
        pid  = pick_arrival_id();
        pick = $urandom_range(0, 99);
        if (pick < 3)       svc = '0;
        else if (pick < 85) svc = mfs_pkg::work_t'($urandom_range(1, 24));
        else                svc = mfs_pkg::work_t'($urandom_range(25, 120));
        send_word(mfs_pkg::REQ_ARRIVAL, pid, svc, taken);
      end else begin
        send_word(mfs_pkg::REQ_TICK, mfs_pkg::id_t'($urandom),
                  mfs_pkg::work_t'($urandom), taken);
      end
      if (taken) sent++;
    end
  endtask

  // Idle slots, dropped arrivals, round robin at level 0, lone requeue
  task automatic test_directed_basics();
    idle_on  = 1'b1;
    stall_on = 1'b1;
    send_tick();
    send_arrival(4'd0, 16'd0);
    send_arrival(4'd15, 16'd1);
    send_arrival(4'd0, 16'd2);
    send_arrival(4'd15, 16'd7);
    send_tick();
    send_tick();
    send_tick();
    send_tick();
    send_arrival(4'd5, 16'hFFFF);
    send_arrival(4'd10, 16'd3);
    send_arrival(4'd6, 16'd4);
    repeat (8) send_tick();
    send_arrival(4'd12, 16'd1);
    repeat (4) send_tick();
  endtask

  // Sweep quantum mode and level count, extremes and out-of-range values too
  task automatic test_feedback_phases();
    logic                        modes [10];
    logic [mfs_pkg::LVCFG_W-1:0] lvls [10];
    modes = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    lvls  = '{5'd16, 5'd16, 5'd1, 5'd2, 5'd4, 5'd0, 5'd31, 5'd17, 5'd8, 5'd5};
    for (int p = 0; p < 10; p++) begin
      wait_drained();
      apply_settings(modes[p], lvls[p]);
      run_traffic(140, $urandom_range(25, 55));
    end
  endtask

  // Dense ticks with long and short jobs mixed in, no idling on either side
  task automatic test_long_jobs();
    int unsigned    start_ticks;
    mfs_pkg::id_t   pid;
    mfs_pkg::work_t svc;
    wait_drained();
    apply_settings(1'b0, 5'd16);
    idle_on     = 1'b0;
    stall_on    = 1'b0;
    start_ticks = ticks_sent;
    while (ticks_sent - start_ticks < 200) begin
      if ($urandom_range(0, 99) < 10) begin
        pid = pick_arrival_id();
        svc = ($urandom_range(0, 1) != 0) ? mfs_pkg::work_t'($urandom_range(1, 300))
                                          : mfs_pkg::work_t'($urandom_range(1, 65535));
        send_arrival(pid, svc);
      end else begin
        send_tick();
      end
    end
  endtask

  // Output-side stalls: mostly short, a few long
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (stall_on && $urandom_range(0, 99) < 20) begin
      stall_left = gap_len() - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      mismatch_count++;
    end
  endtask

  // Compare each report word with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (slot_reports.size() == 0) begin
        $error("slot report at tick_time %0d with nothing expected", tick_time_o);
        mismatch_count++;
      end else begin
        want = slot_reports.pop_front();
        check_field("ran_valid", want.ran_valid, ran_valid_o);
        check_field("ran_id", want.ran_id, ran_id_o);
        check_field("ran_level", want.ran_level, ran_level_o);
        check_field("done_res", want.done_res, done_res_o);
        check_field("tick_time", want.tick_time, tick_time_o);
        reports_checked++;
      end
    end
  end

  // Watchdog: end the run when neither channel moves a word for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o === 1'b1) || (out_valid_o === 1'b1 && out_ready_i)) begin
      idle_cycles = 0;
    end else if (rst_ni) begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout after %0d cycles without a handshake", STALL_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    clear_shadow();
    mismatch_count   = 0;
    reports_checked  = 0;
    ticks_sent       = 0;
    arrivals_taken   = 0;
    settings_applied = 0;
    idle_cycles      = 0;
    stall_left       = 0;
    idle_on          = 1'b0;
    stall_on         = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_basics();
    test_feedback_phases();
    test_long_jobs();
    wait_drained();

    if (slot_reports.size() != 0) begin
      $error("%0d slot reports never arrived", slot_reports.size());
      mismatch_count++;
    end
    $display("Covered %0d ticks and %0d admitted arrivals under %0d register settings,",
             ticks_sent, arrivals_taken, settings_applied);
    $display("with idle and output stalls mixed in; %0d slot reports compared",
             reports_checked);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
